FILE: rtl/core/blve_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package blve_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int VALUE_W   = 32;
	localparam int CMD_W     = 3;
	localparam int COUNT_W   = 7;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH     = 3'd0,
		CMD_DEL_EQ   = 3'd1,
		CMD_DEL_PRED = 3'd2,
		CMD_FIND     = 3'd3,
		CMD_STATUS   = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic               rejected;
		logic [COUNT_W-1:0] removed_count;
		logic [COUNT_W-1:0] entry_count;
		logic               list_empty;
		logic               found;
	} res_t;

endpackage

`default_nettype wire

FILE: rtl/core/blve_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module blve_mem
	import blve_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic               clk,
	input  wire logic               we,
	input  wire logic [AW-1:0]      waddr,
	input  wire logic [VALUE_W-1:0] wdata,
	input  wire logic               re,
	input  wire logic [AW-1:0]      raddr,
	output logic      [VALUE_W-1:0] rdata
);

	logic [VALUE_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/blve_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module blve_seq
	import blve_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH),
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [CMD_W-1:0]   in_cmd,
	input  wire logic [VALUE_W-1:0] in_value,
	output logic                    res_valid,
	input  wire logic               res_ready,
	output res_t                    res,
	output logic                    mem_we,
	output logic      [AW-1:0]      mem_waddr,
	output logic      [VALUE_W-1:0] mem_wdata,
	output logic                    mem_re,
	output logic      [AW-1:0]      mem_raddr,
	input  wire logic [VALUE_W-1:0] mem_rdata
);

	state_t state_q, state_d;

	logic [CMD_W-1:0]   cmd_q;
	logic [VALUE_W-1:0] val_q;
	logic [VALUE_W-1:0] prev_q;
	logic [CW-1:0]      occ_q;
	logic [CW-1:0]      rd_q;
	logic [CW-1:0]      wr_q;
	logic [CW-1:0]      removed_q;
	logic               found_q;
	logic               rej_q;
	logic               v_s1;
	logic               first_s1;

	logic               accept;
	logic               push_ok;
	logic               issue;
	logic               scan_end;
	logic               is_del;
	logic               is_pred;
	logic [VALUE_W-1:0] cmp_a;
	logic               hit;
	logic               keep;
	logic [CW+COUNT_W-1:0] occ_ext;
	logic [CW+COUNT_W-1:0] rem_ext;

	assign accept   = in_valid && in_ready;
	assign push_ok  = accept && (in_cmd == CMD_PUSH) && (occ_q < CW'(DEPTH));
	assign issue    = (state_q == ST_SCAN) && (rd_q < occ_q);
	assign scan_end = (state_q == ST_SCAN) && !issue && !v_s1;
	assign is_pred  = (cmd_q == CMD_DEL_PRED);
	assign is_del   = (cmd_q == CMD_DEL_EQ) || is_pred;

	// one shared comparator: predecessor delete looks at the previous entry
	assign cmp_a = is_pred ? prev_q : mem_rdata;
	assign hit   = (cmp_a == val_q);
	assign keep  = is_pred ? !(hit && !first_s1) : !hit;

	assign mem_re    = issue;
	assign mem_raddr = rd_q[AW-1:0];
	assign mem_we    = push_ok || (v_s1 && is_del && keep);
	assign mem_waddr = push_ok ? occ_q[AW-1:0] : wr_q[AW-1:0];
	assign mem_wdata = push_ok ? in_value : mem_rdata;

	assign occ_ext = {{COUNT_W{1'b0}}, occ_q};
	assign rem_ext = {{COUNT_W{1'b0}}, removed_q};

	always_comb begin
		res.found         = found_q;
		res.list_empty    = (occ_q == '0);
		res.entry_count   = occ_ext[COUNT_W-1:0];
		res.removed_count = rem_ext[COUNT_W-1:0];
		res.rejected      = rej_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_cmd inside {CMD_DEL_EQ, CMD_DEL_PRED, CMD_FIND}) begin
						state_d = ST_SCAN;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_SCAN: begin
				if (scan_end) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			v_s1  <= 1'b0;
		end else begin
			v_s1 <= issue;
			if (push_ok) begin
				occ_q <= occ_q + CW'(1);
			end else if (scan_end && is_del) begin
				occ_q <= wr_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= in_cmd;
			val_q     <= in_value;
			rd_q      <= '0;
			wr_q      <= '0;
			found_q   <= 1'b0;
			removed_q <= '0;
			rej_q     <= (in_cmd == CMD_PUSH) && !push_ok;
		end
		if (issue) begin
			first_s1 <= (rd_q == '0);
			rd_q     <= rd_q + CW'(1);
		end
		if (v_s1) begin
			prev_q <= mem_rdata;
			if ((cmd_q == CMD_FIND) && hit) begin
				found_q <= 1'b1;
			end
			// compaction writes behind the read cursor
			if (is_del && keep) begin
				wr_q <= wr_q + CW'(1);
			end
		end
		if (scan_end && is_del) begin
			removed_q <= occ_q - wr_q;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/bounded_value_list_engine.sv
// push and status: the sequencer goes from idle to done, and the result then loads the output register
// find and deletes: m_tvalid rises after a scan over all stored entries, one
// stored entry per cycle through the single read port and the one shared comparator
// one command at a time, taken once the result is in the output register: no new input is
// accepted while a command is scanning or while its result waits for the output register
// arst_n clears the sequencer, the entry count and the output valid; entry storage is not cleared
`timescale 1ns / 1ps
`default_nettype none

module bounded_value_list_engine
	import blve_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // item_value
	input  wire logic [2:0]  s_tuser,  // cmd
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [23:0] m_tdata   // found, list_empty, entry_count, removed_count, rejected
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic               res_valid;
	logic               res_ready;
	res_t               res;
	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [VALUE_W-1:0] mem_wdata;
	logic               mem_re;
	logic [AW-1:0]      mem_raddr;
	logic [VALUE_W-1:0] mem_rdata;
	logic               m_tvalid_q;
	logic [23:0]        m_tdata_q;

	blve_seq #(
		.DEPTH(DEPTH),
		.AW   (AW),
		.CW   (CW)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_cmd   (s_tuser),
		.in_value (s_tdata),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re   (mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	blve_mem #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// output register, refilled in the cycle the previous result transfers
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_tdata_q <= {7'd0, res};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

`default_nettype wire

FILE: tb/tb_bounded_value_list_engine.sv
`timescale 1ns / 1ps

module tb_bounded_value_list_engine;
	import blve_pkg::*;

	localparam int LIST_DEPTH    = DEPTH_DEF;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 100;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int RES_W         = $bits(res_t);

	localparam logic [VALUE_W-1:0] VALUE_POOL [6] = '{
		32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
		32'h7FFF_FFFF, 32'h0000_0001, 32'h5A5A_5A5A
	};

	typedef struct {
		logic [CMD_W-1:0]   cmd;
		logic [VALUE_W-1:0] value;
	} list_req_t;

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [31:0]        s_tdata  = '0;
	logic [2:0]         s_tuser  = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [23:0]        m_tdata;

	list_req_t pending_cmds [$];
	res_t      expected_results [$];

	// predictor copy of the list: index 0 is the tail, list_len-1 the head
	logic [VALUE_W-1:0] list_mem [LIST_DEPTH];
	int                 list_len = 0;

	int   send_idle_pct = 11;
	int   recv_idle_pct = 53;
	logic hold_go       = 1'b0;
	int   hold_left     = 0;
	logic in_fire       = 1'b0;
	int   queued_cnt    = 0;
	int   accepted_cnt  = 0;
	int   mismatches    = 0;
	int   cycles        = 0;

	bounded_value_list_engine #(
		.DEPTH(LIST_DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #1 clk = ~clk;

	function automatic res_t list_model_apply(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] v);
		res_t               r;
		logic [VALUE_W-1:0] orig [LIST_DEPTH];
		int                 w;
		int                 removed;
		r       = '0;
		removed = 0;
		w       = 0;
		case (cmd)
			CMD_PUSH: begin
				if (list_len >= LIST_DEPTH) begin
					r.rejected = 1'b1;
				end else begin
					list_mem[list_len] = v;
					list_len++;
				end
			end
			CMD_DEL_EQ: begin
				for (int i = 0; i < list_len; i++) begin
					if (list_mem[i] != v) begin
						list_mem[w] = list_mem[i];
						w++;
					end
				end
				removed  = list_len - w;
				list_len = w;
			end
			CMD_DEL_PRED: begin
				// successor of entry i is entry i-1 of the list as it stood
				orig = list_mem;
				for (int i = 0; i < list_len; i++) begin
					if (!(i > 0 && orig[i-1] == v)) begin
						list_mem[w] = orig[i];
						w++;
					end
				end
				removed  = list_len - w;
				list_len = w;
			end
			CMD_FIND: begin
				for (int i = 0; i < list_len; i++) begin
					if (list_mem[i] == v)
						r.found = 1'b1;
				end
			end
			default: ;
		endcase
		r.list_empty    = (list_len == 0);
		r.entry_count   = COUNT_W'(list_len);
		r.removed_count = COUNT_W'(removed);
		return r;
	endfunction

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch on %s: expected %0d, got %0d", name, want, got);
		end
	endtask

	// outputs checked first, then the input transfer is predicted
	always @(posedge clk) begin : result_check
		res_t want;
		res_t got;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = res_t'(m_tdata[RES_W-1:0]);
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result transfer with nothing expected: %h", m_tdata);
				end else begin
					want = expected_results.pop_front();
					check_field("found", want.found, got.found);
					check_field("list_empty", want.list_empty, got.list_empty);
					check_field("entry_count", want.entry_count, got.entry_count);
					check_field("removed_count", want.removed_count, got.removed_count);
					check_field("rejected", want.rejected, got.rejected);
					check_field("padding", 0, m_tdata[23:RES_W]);
				end
			end
			in_fire <= s_tvalid && s_tready;
			if (s_tvalid && s_tready) begin
				expected_results.push_back(list_model_apply(s_tuser, s_tdata));
				accepted_cnt++;
			end
		end else begin
			in_fire <= 1'b0;
		end
	end

	always @(negedge clk) begin : cmd_driver
		list_req_t req;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || in_fire) begin
			if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				req = pending_cmds.pop_front();
				s_tvalid <= 1'b1;
				s_tuser  <= req.cmd;
				s_tdata  <= req.value;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : result_sink
		if (hold_go) begin
			hold_go   = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic queue_cmd(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] value);
		pending_cmds.push_back('{cmd, value});
		queued_cnt++;
	endtask

	function automatic logic [VALUE_W-1:0] pick_value();
		// mostly a small pool so deletes and finds hit, sometimes any pattern
		if ($urandom_range(9) < 7)
			return VALUE_POOL[$urandom_range(5)];
		return $urandom();
	endfunction

	task automatic queue_random(int n, int push_pct);
		logic [CMD_W-1:0] cmd;
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(99) < push_pct) begin
				cmd = CMD_PUSH;
			end else begin
				case ($urandom_range(9))
					0, 1, 2: cmd = CMD_DEL_EQ;
					3, 4:    cmd = CMD_DEL_PRED;
					5, 6:    cmd = CMD_FIND;
					7:       cmd = CMD_STATUS;
					default: cmd = CMD_W'($urandom_range(7, CMD_STATUS + 1));
				endcase
			end
			queue_cmd(cmd, pick_value());
		end
	endtask

	task automatic wait_drained();
		while (!(accepted_cnt == queued_cnt && expected_results.size() == 0))
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic run_phase(int send_pct, int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		queue_random(90, 92);   // fill up to full, then refused pushes
		queue_random(150, 45);
		queue_random(120, 15);  // deletes drain the list
		queue_random(100, 92);
		wait_drained();
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list: nothing to delete or find
		queue_cmd(CMD_STATUS, 32'h0);
		queue_cmd(CMD_FIND, 32'h0);
		queue_cmd(CMD_DEL_EQ, 32'h0);
		queue_cmd(CMD_DEL_PRED, 32'h0);
		for (int c = CMD_STATUS + 1; c < 8; c++)
			queue_cmd(CMD_W'(c), 32'hFFFF_FFFF);
		queue_cmd(CMD_PUSH, 32'h8000_0000);
		queue_cmd(CMD_PUSH, 32'h7FFF_FFFF);
		queue_cmd(CMD_PUSH, 32'h0000_0000);
		queue_cmd(CMD_PUSH, 32'hFFFF_FFFF);
		queue_cmd(CMD_PUSH, 32'h7FFF_FFFF);
		queue_cmd(CMD_FIND, 32'h7FFF_FFFF);
		queue_cmd(CMD_FIND, 32'h1234_5678);
		queue_cmd(CMD_DEL_PRED, 32'h7FFF_FFFF);
		// the tail value as successor, the tail itself stays
		queue_cmd(CMD_DEL_PRED, 32'h8000_0000);
		queue_cmd(CMD_DEL_EQ, 32'h7FFF_FFFF);
		queue_cmd(CMD_PUSH, 32'h0000_0001);
		queue_cmd(CMD_PUSH, 32'h0000_0001);
		queue_cmd(CMD_PUSH, 32'h0000_0001);
		queue_cmd(CMD_DEL_EQ, 32'h0000_0001);
		queue_cmd(CMD_DEL_EQ, 32'hFFFF_FFFF);
		queue_cmd(CMD_DEL_EQ, 32'h8000_0000);
		queue_cmd(CMD_STATUS, 32'h0);

		run_phase(11, 53);

		// long receiver stall while commands keep coming
		hold_go = 1'b1;
		queue_random(30, 50);
		wait_drained();

		run_phase(53, 11);
		run_phase(0, 0);

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

FILE: bounded_value_list_engine.f
rtl/core/blve_pkg.sv
rtl/core/blve_mem.sv
rtl/core/blve_seq.sv
rtl/core/bounded_value_list_engine.sv
tb/tb_bounded_value_list_engine.sv
